// ----- rtl/gfd_pkg.sv -----
// ----------------------------------------------------------------------------
// gfd_pkg: shared types and constants for the gamepad frame decoder
// Sequencer states and the CORDIC arctangent table (degrees * 65536).
// ----------------------------------------------------------------------------
package gfd_pkg;

  localparam int ZW = 28;  // angle accumulator width, degrees * 65536

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ITER,
    ST_WRAP,
    ST_DONE,
    ST_OUT
  } state_t;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    begin
      case (i)
        5'd0:  v = 28'sd2949120;
        5'd1:  v = 28'sd1740967;
        5'd2:  v = 28'sd919879;
        5'd3:  v = 28'sd466945;
        5'd4:  v = 28'sd234379;
        5'd5:  v = 28'sd117304;
        5'd6:  v = 28'sd58666;
        5'd7:  v = 28'sd29335;
        5'd8:  v = 28'sd14668;
        5'd9:  v = 28'sd7334;
        5'd10: v = 28'sd3667;
        5'd11: v = 28'sd1833;
        5'd12: v = 28'sd917;
        5'd13: v = 28'sd458;
        5'd14: v = 28'sd229;
        5'd15: v = 28'sd115;
        5'd16: v = 28'sd57;
        5'd17: v = 28'sd29;
        5'd18: v = 28'sd14;
        5'd19: v = 28'sd7;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- rtl/gamepad_frame_decoder_top.sv -----
// ----------------------------------------------------------------------------
// gamepad_frame_decoder_top
// Collects 16 slot nibbles from serial bytes, decodes buttons, triggers and
// sticks, and computes both stick angles with one shared CORDIC unit.
// ----------------------------------------------------------------------------
// A byte that does not end a frame is taken without leaving ST_IDLE. After the 16th byte
// out_tvalid rises once both sticks are done (one CORDIC pass per stick,
// one after the other on a single shift/add unit; a centred stick
// skips its pass and goes from ST_LOAD straight to ST_DONE).
// Throughput: one byte per cycle except from the 16th byte until the result
// beat is taken. Reset (rst_n low, synchronous): byte count, press history,
// toggles clear, the stick deadzone returns to 10.
module gamepad_frame_decoder_top #(
  parameter int ANGLE_FRAC_BITS = 4,
  parameter int CORDIC_STEPS    = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [16:0] press_bits, [33:17] edge_bits, [50:34] toggle_bits,
  // [58:51] left_trigger_level, [66:59] right_trigger_level,
  // [75:67] left_stick_x, [84:76] left_stick_y, [93:85] right_stick_x,
  // [102:94] right_stick_y, [116:103] left_angle, [130:117] right_angle,
  // [135:131] zero
  output logic [135:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data
);

  localparam int ZW = gfd_pkg::ZW;
  localparam int CW = 22;  // CORDIC x/y width: |v|*4096*1.65 fits
  localparam logic signed [ZW-1:0] DEG360 = ZW'(360 * 65536);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);

  gfd_pkg::state_t state_r, state_nxt;

  logic [3:0]  slot_r [16];
  logic [3:0]  cnt_r;
  logic [16:0] prev_r, tog_r;
  logic [6:0]  db_r;
  logic        side_r;      // 0: left stick, 1: right stick
  logic [4:0]  it_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic [135:0] res_r;

  logic in_acc, last_byte;
  assign in_tready = (state_r == gfd_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid & in_tready;
  assign last_byte = in_acc & (cnt_r == 4'd15);
  assign out_tvalid = (state_r == gfd_pkg::ST_OUT);
  assign out_tdata  = res_r;

  // slot view including the current byte
  logic [3:0] sv [16];
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      sv[k] = slot_r[k];
    end
    sv[in_tdata[3:0]] = in_tdata[7:4];
  end

  function automatic logic signed [8:0] band(input logic [7:0] v, input logic [6:0] db);
    logic signed [8:0] d, m;
    begin
      d = $signed({1'b0, v}) - 9'sd128;
      m = d[8] ? -d : d;
      if (m <= $signed({2'b00, db})) return '0;
      return d[8] ? d + $signed({2'b00, db}) : d - $signed({2'b00, db});
    end
  endfunction

  logic [16:0] press;
  logic [16:0] edg;
  logic [7:0]  v4, v6;
  logic signed [8:0] lx, ly, rx, ry;
  always_comb begin
    for (int s = 0; s < 4; s++) begin
      for (int k = 0; k < 4; k++) begin
        press[4*s+k] = sv[s][3-k];
      end
    end
    press[15] = (sv[4] != 4'd0);
    press[16] = (sv[6] != 4'd0);
    edg = press & ~prev_r;
    v4 = {sv[4], sv[5]};
    v6 = {sv[6], sv[7]};
    lx = band({sv[8], sv[9]}, db_r);
    ly = -band({sv[10], sv[11]}, db_r);
    rx = band({sv[12], sv[13]}, db_r);
    ry = -band({sv[14], sv[15]}, db_r);
  end

  // CORDIC operands for the selected stick
  logic signed [8:0] sx, sy;
  assign sx = side_r ? $signed(res_r[93:85]) : $signed(res_r[75:67]);
  assign sy = side_r ? $signed(res_r[102:94]) : $signed(res_r[84:76]);

  logic signed [CW-1:0] xs, ys;
  assign xs = cx_r >>> it_r;
  assign ys = cy_r >>> it_r;

  // wrap and round
  logic signed [ZW-1:0] zw;
  logic signed [ZW-1:0] rnd;
  always_comb begin
    zw = cz_r;
    if (zw < 0) zw = zw + DEG360;
    else if (zw >= DEG360) zw = zw - DEG360;
    rnd = (zw + ZW'(1 << (15 - ANGLE_FRAC_BITS))) >>> (16 - ANGLE_FRAC_BITS);
    if (rnd >= ZW'(360 << ANGLE_FRAC_BITS)) rnd = rnd - ZW'(360 << ANGLE_FRAC_BITS);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gfd_pkg::ST_IDLE: if (last_byte) state_nxt = gfd_pkg::ST_LOAD;
      gfd_pkg::ST_LOAD: begin
        if (sx == 9'sd0 && sy == 9'sd0) state_nxt = gfd_pkg::ST_DONE;
        else state_nxt = gfd_pkg::ST_ITER;
      end
      gfd_pkg::ST_ITER: if (it_r == 5'(CORDIC_STEPS - 1)) state_nxt = gfd_pkg::ST_WRAP;
      gfd_pkg::ST_WRAP: state_nxt = gfd_pkg::ST_DONE;
      gfd_pkg::ST_DONE: state_nxt = side_r ? gfd_pkg::ST_OUT : gfd_pkg::ST_LOAD;
      gfd_pkg::ST_OUT:  if (out_tready) state_nxt = gfd_pkg::ST_IDLE;
      default:          state_nxt = gfd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gfd_pkg::ST_IDLE;
      cnt_r   <= '0;
      prev_r  <= '0;
      tog_r   <= '0;
      db_r    <= 7'd10;
      side_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) db_r <= cfg_data;
      if (in_acc) begin
        cnt_r <= cnt_r + 4'd1;
        if (last_byte) begin
          prev_r <= press;
          tog_r  <= tog_r ^ edg;
          side_r <= 1'b0;
        end
      end
      if (state_r == gfd_pkg::ST_DONE) side_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) slot_r[in_tdata[3:0]] <= in_tdata[7:4];
    if (last_byte) begin
      res_r[16:0]   <= press;
      res_r[33:17]  <= edg;
      res_r[50:34]  <= tog_r ^ edg;
      res_r[58:51]  <= (v4 > 8'd15) ? v4 - 8'd16 : 8'd0;
      res_r[66:59]  <= (v6 > 8'd15) ? v6 - 8'd16 : 8'd0;
      res_r[75:67]  <= lx;
      res_r[84:76]  <= ly;
      res_r[93:85]  <= rx;
      res_r[102:94] <= ry;
      res_r[135:103] <= '0;
    end
    unique case (state_r)
      gfd_pkg::ST_LOAD: begin
        it_r <= '0;
        if (sx == 9'sd0 && sy == 9'sd0) begin
          // centred stick reads as minus one degree
          cx_r <= '0;
          cy_r <= '0;
          cz_r <= ZW'(-(1 << ANGLE_FRAC_BITS));
        end else if (sx < 0) begin
          cx_r <= -(CW'(sx) <<< 12);
          cy_r <= -(CW'(sy) <<< 12);
          cz_r <= DEG180;
        end else begin
          cx_r <= CW'(sx) <<< 12;
          cy_r <= CW'(sy) <<< 12;
          cz_r <= '0;
        end
      end
      gfd_pkg::ST_ITER: begin
        it_r <= it_r + 5'd1;
        if (!cy_r[CW-1]) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + gfd_pkg::atan_deg(it_r);
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - gfd_pkg::atan_deg(it_r);
        end
      end
      // cz_r now holds the rounded angle at output scale
      gfd_pkg::ST_WRAP: cz_r <= rnd;
      gfd_pkg::ST_DONE: begin
        if (side_r) res_r[130:117] <= cz_r[13:0];
        else        res_r[116:103] <= cz_r[13:0];
      end
      default: ;
    endcase
  end

  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != gfd_pkg::ST_IDLE) |-> !in_tready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gfd_pkg::ST_ITER) |-> (it_r < 5'(CORDIC_STEPS))) else $error("iter overrun");

endmodule
